// ===== sv/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
package tcw_pkg;

   // Field widths of the request and response words.
   localparam int FUNC_W       = 1;
   localparam int CHAR_W       = 8;
   localparam int READ_ROW_W   = 5;
   localparam int READ_COL_W   = 6;
   localparam int CURSOR_COL_W = 7;
   localparam int CURSOR_ROW_W = 6;

   // Access codes carried in the func field.
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b1;

   // Control characters that move the cursor without storing anything.
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL,
      ST_ADDR,
      ST_MEM,
      ST_DONE
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_ready;
      logic sweep_all;
      logic sweep_row;
      logic addr_load;
      logic mem_access;
      logic rsp_read;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_valid;
      logic slot_free;
      logic is_read;
      logic is_ctrl;
      logic will_scroll;
      logic all_last;
      logic row_last;
      logic pending_read;
   } status_type;

endpackage

// ===== sv/tcw_req_if.sv =====
// Request channel: one console access per word.
interface tcw_req_if
   import tcw_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic [CHAR_W-1:0]       char_code;
   logic [READ_ROW_W-1:0]   read_row;
   logic [READ_COL_W-1:0]   read_col;

   modport source (output valid, func, char_code, read_row, read_col, input ready);
   modport sink   (input valid, func, char_code, read_row, read_col, output ready);
endinterface

// ===== sv/tcw_rsp_if.sv =====
// Response channel: one result word per access.
interface tcw_rsp_if
   import tcw_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [CHAR_W-1:0]       read_char;
   logic [CURSOR_COL_W-1:0] cursor_col;
   logic [CURSOR_ROW_W-1:0] cursor_row;
   logic                    scrolled;

   modport source (output valid, read_char, cursor_col, cursor_row, scrolled, input ready);
   modport sink   (input valid, read_char, cursor_col, cursor_row, scrolled, output ready);
endinterface

// ===== sv/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   // State register; reset starts the clearing pass over the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_all = 1'b1;
            if (status.all_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.take_ready = status.slot_free;
            if (status.slot_free && status.req_valid) begin
               priority if (status.is_read) begin
                  state_in = ST_ADDR;
               end else if (status.is_ctrl) begin
                  state_in = ST_IDLE;
               end else if (status.will_scroll) begin
                  state_in = ST_SCROLL;
               end else begin
                  state_in = ST_ADDR;
               end
            end
         end
         ST_SCROLL: begin
            cmd.sweep_row = 1'b1;
            if (status.row_last) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.addr_load = 1'b1;
            state_in      = ST_MEM;
         end
         ST_MEM: begin
            cmd.mem_access = 1'b1;
            state_in       = status.pending_read ? ST_DONE : ST_IDLE;
         end
         ST_DONE: begin
            cmd.rsp_read = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/tcw_datapath.sv =====
// Datapath of the text console writer: cursor, row offset, text store and response register.
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int ROWS = 32,
   parameter int COLS = 64
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int RW       = $clog2(ROWS + 1);
   localparam int CW       = $clog2(COLS + 1);
   localparam int RAW      = $clog2(ROWS);
   localparam int CAW      = $clog2(COLS);
   localparam int AW       = RAW + CAW;
   localparam int COL_SPAN = 2 ** CAW;
   localparam int DEPTH    = ROWS * COL_SPAN;

   localparam logic [RW-1:0]  ROW_LIMIT = RW'(ROWS);
   localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
   localparam logic [CW-1:0]  COL_LIMIT = CW'(COLS);
   localparam logic [CAW-1:0] COL_LAST  = CAW'(COLS - 1);
   localparam logic [AW-1:0]  ADDR_LAST = AW'(DEPTH - 1);

   // Cursor and scroll state.
   logic [CW-1:0]  cur_col_ff, cur_col_in;
   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [RAW-1:0] top_ff, top_in;

   // Latched access.
   logic              func_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic [RW-1:0]     row_sel_ff;
   logic [CAW-1:0]    col_sel_ff;
   logic              in_grid_ff;
   logic              scroll_ff;
   logic [RAW-1:0]    clr_row_ff;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     sweep_ff;

   // Text store and its read register.
   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic [CHAR_W-1:0]       rsp_char_ff;
   logic [CURSOR_COL_W-1:0] rsp_col_ff;
   logic [CURSOR_ROW_W-1:0] rsp_row_ff;
   logic                    rsp_scrolled_ff;

   logic           accept;
   logic           is_read, is_ctrl, is_nl, is_bs, is_cr;
   logic           wrap, will_scroll;
   logic [CW-1:0]  col_w;
   logic [RW-1:0]  row_next, row_w, row_f;
   logic           in_grid;
   logic [RW:0]    row_sum;
   logic [RAW-1:0] prow;
   logic           rsp_load;
   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   logic [CHAR_W-1:0] mem_wd;

   assign req_ch.ready = cmd.take_ready;
   assign accept       = req_ch.valid && cmd.take_ready;

   // Decode of the incoming word.
   assign is_read = (req_ch.func == FUNC_READ);
   assign is_nl   = (req_ch.char_code == CHAR_NEWLINE);
   assign is_bs   = (req_ch.char_code == CHAR_BACKSPACE);
   assign is_cr   = (req_ch.char_code == CHAR_RETURN);
   assign is_ctrl = !is_read && (is_nl || is_bs || is_cr);

   // Row advance saturates one past the bottom, so repeated newlines scroll once.
   assign row_next = (cur_row_ff >= ROW_LIMIT) ? ROW_LIMIT : cur_row_ff + RW'(1);

   // A pending wrap moves to the next row before a character is stored.
   assign wrap        = (cur_col_ff >= COL_LIMIT);
   assign col_w       = wrap ? '0 : cur_col_ff;
   assign row_w       = wrap ? row_next : cur_row_ff;
   assign will_scroll = (row_w > ROW_LAST);
   assign row_f       = will_scroll ? ROW_LAST : row_w;

   assign in_grid = ({2'b00, req_ch.read_row} < 7'(ROWS)) &&
                    ({3'b000, req_ch.read_col} < 9'(COLS));

   // Next cursor position.
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      top_in     = top_ff;
      if (accept && !is_read) begin
         priority if (is_nl) begin
            cur_col_in = '0;
            cur_row_in = row_next;
         end else if (is_bs) begin
            if (cur_col_ff != '0) begin
               cur_col_in = cur_col_ff - CW'(1);
            end
         end else if (is_cr) begin
            cur_col_in = '0;
         end else begin
            cur_col_in = col_w + CW'(1);
            cur_row_in = row_f;
            if (will_scroll) begin
               top_in = (top_ff == RAW'(ROWS - 1)) ? '0 : top_ff + RAW'(1);
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         top_ff     <= '0;
         sweep_ff   <= '0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         top_ff     <= top_in;
         if (accept) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_all || cmd.sweep_row) begin
            sweep_ff <= sweep_ff + AW'(1);
         end
      end
   end

   // Latch the access; a scroll remembers the old top row, which becomes the bottom.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= is_read;
         ch_ff      <= req_ch.char_code;
         in_grid_ff <= in_grid;
         scroll_ff  <= !is_read && !is_ctrl && will_scroll;
         clr_row_ff <= top_ff;
         if (is_read) begin
            row_sel_ff <= RW'(req_ch.read_row);
            col_sel_ff <= CAW'(req_ch.read_col);
         end else begin
            row_sel_ff <= row_f;
            col_sel_ff <= CAW'(col_w);
         end
      end
   end

   // Visible row to physical row through the circular offset.
   assign row_sum = (RW + 1)'(top_ff) + (RW + 1)'(row_sel_ff);
   assign prow    = (row_sum >= (RW + 1)'(ROWS)) ? RAW'(row_sum - (RW + 1)'(ROWS))
                                                 : RAW'(row_sum);

   always_ff @(posedge clock) begin
      if (cmd.addr_load) begin
         addr_ff <= {prow, col_sel_ff};
      end
   end

   // Store write port: clearing sweeps or a character write.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = ch_ff;
      if (cmd.sweep_all) begin
         mem_we = 1'b1;
         mem_wa = sweep_ff;
         mem_wd = '0;
      end else if (cmd.sweep_row) begin
         mem_we = 1'b1;
         mem_wa = {clr_row_ff, sweep_ff[CAW-1:0]};
         mem_wd = '0;
      end else if (cmd.mem_access && !func_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.mem_access && func_ff) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // Response register.
   assign rsp_load = (accept && is_ctrl) || (cmd.mem_access && !func_ff) || cmd.rsp_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_char_ff     <= (cmd.rsp_read && in_grid_ff) ? rd_data_ff : '0;
         rsp_col_ff      <= CURSOR_COL_W'(cur_col_in);
         rsp_row_ff      <= CURSOR_ROW_W'(cur_row_in);
         rsp_scrolled_ff <= cmd.mem_access && !func_ff && scroll_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_char  = rsp_char_ff;
   assign rsp_ch.cursor_col = rsp_col_ff;
   assign rsp_ch.cursor_row = rsp_row_ff;
   assign rsp_ch.scrolled   = rsp_scrolled_ff;

   // Status for the controller.
   always_comb begin
      status              = '0;
      status.req_valid    = req_ch.valid;
      status.slot_free    = !rsp_valid_ff || rsp_ch.ready;
      status.is_read      = is_read;
      status.is_ctrl      = is_ctrl;
      status.will_scroll  = will_scroll;
      status.all_last     = (sweep_ff == ADDR_LAST);
      status.row_last     = (sweep_ff[CAW-1:0] == COL_LAST);
      status.pending_read = func_ff;
   end

endmodule

// ===== sv/text_console_writer_unit.sv =====
// Character-cell text console with cursor handling and one-line scrolling.
// The console holds ROWS x COLS byte cells. Each request word is one access:
// a character write at the cursor, or a read of one cell. Newline, backspace
// and carriage return only move the cursor; their result is registered as they
// are accepted. A stored character passes through accept, address and store
// write; on a scroll a clearing state first zeros the COLS cells of the new
// bottom row. A read adds a response state after the store access, set by the
// registered read of the single-port text store. After reset a clearing pass
// writes zeros to the whole store, one cell a cycle, and no request is taken
// until it ends. Results sit in an output register; a result that is not yet
// taken holds off the next request, and a result taken in the cycle it is
// offered lets the next request in during that same cycle.
module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int ROWS = 32,
   parameter int COLS = 64
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_ch,
   tcw_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // Sequencing of each access.
   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Cursor, store and response register.
   tcw_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the text console writer: cursor moves, wrap, scroll and cell reads.
module tb_top;
   import tcw_pkg::*;

   localparam int ROWS          = 32;
   localparam int COLS          = 64;
   localparam int STALL_LIMIT   = 10000;
   localparam int SETTLE_CYCLES = 100;

   // One request word and one response word, as the console sees them.
   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [CHAR_W-1:0]     char_code;
      logic [READ_ROW_W-1:0] read_row;
      logic [READ_COL_W-1:0] read_col;
   } console_access_type;

   typedef struct packed {
      logic [CHAR_W-1:0]       read_char;
      logic [CURSOR_COL_W-1:0] cursor_col;
      logic [CURSOR_ROW_W-1:0] cursor_row;
      logic                    scrolled;
   } console_report_type;

   logic clock;
   logic reset;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_writer_unit #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Mirror of the console: cell grid, circular top row and cursor.
   logic [CHAR_W-1:0] screen_cells [ROWS][COLS];
   int                screen_top;
   int                cursor_col;
   int                cursor_row;

   console_report_type expected_reports [$];
   int                 mismatches;
   int                 sender_idle_pct;
   int                 receiver_idle_pct;
   int                 stall_cycles;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic clear_screen_model();
      foreach (screen_cells[r, c]) screen_cells[r][c] = '0;
      screen_top = 0;
      cursor_col = 0;
      cursor_row = 0;
   endtask

   // The cursor row stops at ROWS, so a run of newlines at the bottom scrolls only once.
   function automatic int step_down(int r);
      return (r >= ROWS) ? ROWS : r + 1;
   endfunction

   // Applies one access to the mirror and returns the response it should produce.
   function automatic console_report_type apply_console_access(console_access_type acc);
      console_report_type rep;
      rep = '0;
      if (acc.func == FUNC_READ) begin
         if (int'(acc.read_row) < ROWS && int'(acc.read_col) < COLS) begin
            rep.read_char = screen_cells[(screen_top + int'(acc.read_row)) % ROWS][acc.read_col];
         end
      end else if (acc.char_code == CHAR_NEWLINE) begin
         cursor_col = 0;
         cursor_row = step_down(cursor_row);
      end else if (acc.char_code == CHAR_BACKSPACE) begin
         if (cursor_col > 0) cursor_col--;
      end else if (acc.char_code == CHAR_RETURN) begin
         cursor_col = 0;
      end else begin
         // A pending wrap is resolved before the store, then a row past the bottom scrolls.
         if (cursor_col > COLS - 1) begin
            cursor_col = 0;
            cursor_row = step_down(cursor_row);
         end
         if (cursor_row > ROWS - 1) begin
            for (int c = 0; c < COLS; c++) screen_cells[screen_top][c] = '0;
            screen_top   = (screen_top + 1) % ROWS;
            rep.scrolled = 1'b1;
            cursor_row   = ROWS - 1;
         end
         screen_cells[(screen_top + cursor_row) % ROWS][cursor_col] = acc.char_code;
         cursor_col++;
      end
      rep.cursor_col = cursor_col[CURSOR_COL_W-1:0];
      rep.cursor_row = cursor_row[CURSOR_ROW_W-1:0];
      return rep;
   endfunction

   function automatic console_access_type write_word(logic [CHAR_W-1:0] ch);
      console_access_type acc;
      acc           = '0;
      acc.func      = FUNC_WRITE;
      acc.char_code = ch;
      acc.read_row  = READ_ROW_W'($urandom);
      acc.read_col  = READ_COL_W'($urandom);
      return acc;
   endfunction

   function automatic console_access_type read_word(int row, int col);
      console_access_type acc;
      acc           = '0;
      acc.func      = FUNC_READ;
      acc.char_code = CHAR_W'($urandom);
      acc.read_row  = row[READ_ROW_W-1:0];
      acc.read_col  = col[READ_COL_W-1:0];
      return acc;
   endfunction

   // A byte of any value that is never one of the cursor control characters.
   function automatic logic [CHAR_W-1:0] random_glyph();
      logic [CHAR_W-1:0] ch;
      do ch = CHAR_W'($urandom_range(0, 255));
      while (ch == CHAR_NEWLINE || ch == CHAR_BACKSPACE || ch == CHAR_RETURN);
      return ch;
   endfunction

   // Sends one word with a random lead-in gap, then records its expected response.
   task automatic send_access(console_access_type acc);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.func      <= acc.func;
      req_ch.char_code <= acc.char_code;
      req_ch.read_row  <= acc.read_row;
      req_ch.read_col  <= acc.read_col;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_reports.push_back(apply_console_access(acc));
   endtask

   // Holds the request side quiet until every outstanding response is back.
   task automatic wait_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Extremes of the byte range, every control character and reads of three corners.
   task automatic test_directed_basics();
      send_access(read_word(0, 0));
      send_access(read_word(ROWS - 1, COLS - 1));
      send_access(write_word(8'h00));
      send_access(write_word(8'hFF));
      send_access(write_word(8'h41));
      send_access(read_word(0, 0));
      send_access(read_word(0, 1));
      send_access(read_word(0, 2));
      send_access(write_word(CHAR_BACKSPACE));
      send_access(write_word(CHAR_BACKSPACE));
      send_access(write_word(CHAR_BACKSPACE));
      // Backspace at column zero stays at column zero.
      send_access(write_word(CHAR_BACKSPACE));
      send_access(write_word(8'h7F));
      send_access(write_word(CHAR_RETURN));
      send_access(write_word(8'h80));
      send_access(write_word(CHAR_NEWLINE));
      send_access(write_word(8'h01));
      send_access(read_word(0, 0));
      send_access(read_word(1, 0));
      send_access(read_word(ROWS - 1, 0));
   endtask

   // Fills one row to the pending wrap, backs up over it, then wraps for real.
   task automatic test_row_wrap();
      send_access(write_word(CHAR_NEWLINE));
      for (int c = 0; c < COLS; c++) send_access(write_word(random_glyph()));
      // Backspace while a wrap is pending lands on the last column.
      send_access(write_word(CHAR_BACKSPACE));
      send_access(write_word(random_glyph()));
      send_access(write_word(random_glyph()));
      send_access(write_word(random_glyph()));
      for (int k = 0; k < 4; k++) begin
         send_access(read_word(cursor_row - 1, $urandom_range(0, COLS - 1)));
      end
      send_access(read_word(cursor_row - 1, COLS - 1));
      send_access(read_word(cursor_row, 0));
   endtask

   // Runs the cursor past the bottom with extra newlines; only one scroll may follow.
   task automatic test_bottom_scroll();
      for (int k = 0; k < ROWS + 2; k++) send_access(write_word(CHAR_NEWLINE));
      // Control characters at the saturated row never scroll.
      send_access(write_word(CHAR_BACKSPACE));
      send_access(write_word(CHAR_RETURN));
      send_access(write_word(random_glyph()));
      send_access(write_word(random_glyph()));
      send_access(write_word(CHAR_NEWLINE));
      send_access(write_word(CHAR_NEWLINE));
      send_access(write_word(random_glyph()));
      send_access(read_word(ROWS - 1, 0));
      send_access(read_word(ROWS - 2, 0));
      send_access(read_word(ROWS - 2, 1));
      send_access(read_word(0, 0));
   endtask

   // Mixed traffic: text with control characters sprinkled in, reads biased to the bottom.
   task automatic test_random_traffic(int count);
      console_access_type acc;
      int                 pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            if ($urandom_range(0, 1) == 1)
               acc = read_word($urandom_range(ROWS - 8, ROWS - 1), $urandom_range(0, 15));
            else
               acc = read_word($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
         end else if (pick < 32) begin
            acc = write_word(CHAR_NEWLINE);
         end else if (pick < 36) begin
            acc = write_word(CHAR_BACKSPACE);
         end else if (pick < 40) begin
            acc = write_word(CHAR_RETURN);
         end else begin
            acc = write_word(CHAR_W'($urandom_range(0, 255)));
         end
         send_access(acc);
      end
   endtask

   // Response side: random back-pressure driven at the falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Compares each accepted response with the oldest expectation.
   always @(posedge clock) begin : check_responses
      console_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("response word with nothing expected", 1, 0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_ch.read_char !== want.read_char)
               report_mismatch("read_char", rsp_ch.read_char, want.read_char);
            if (rsp_ch.cursor_col !== want.cursor_col)
               report_mismatch("cursor_col", rsp_ch.cursor_col, want.cursor_col);
            if (rsp_ch.cursor_row !== want.cursor_row)
               report_mismatch("cursor_row", rsp_ch.cursor_row, want.cursor_row);
            if (rsp_ch.scrolled !== want.scrolled)
               report_mismatch("scrolled", rsp_ch.scrolled, want.scrolled);
         end
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("ERROR: no word accepted for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      mismatches        = 0;
      stall_cycles      = 0;
      sender_idle_pct   = 34;
      receiver_idle_pct = 78;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_WRITE;
      req_ch.char_code  = '0;
      req_ch.read_row   = '0;
      req_ch.read_col   = '0;
      reset             = 1'b1;
      clear_screen_model();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_row_wrap();
      test_random_traffic(100);
      wait_until_drained();

      sender_idle_pct   = 78;
      receiver_idle_pct = 34;
      test_bottom_scroll();
      test_random_traffic(100);
      wait_until_drained();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_traffic(100);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (expected_reports.size() != 0)
            report_mismatch("responses still outstanding", 0, expected_reports.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
